// File: rtl/ers_pkg.sv
`default_nettype none
package ers_pkg;

    // Fixed-point format of every sample and result.
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 6;
    localparam int LEN_W   = 7;
    localparam int INV_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W  = 3 * DATA_W;
    // Multiplier operands hold a four-term difference of samples.
    localparam int OPW     = DATA_W + 2;
    localparam int PROD_W  = 2 * OPW;
    localparam int SUM_W   = DATA_W + 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DZ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADV_EN     = 3'd4;

    typedef struct packed {
        logic                     first_of_grid;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] vel_z;
        logic signed [DATA_W-1:0] density_pert;
        logic signed [DATA_W-1:0] density_bg;
        logic signed [DATA_W-1:0] gravity_val;
        logic signed [DATA_W-1:0] gravity_grad;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] rhs_value;
        logic [ROW_W-1:0]         row_index;
        logic [COL_W-1:0]         col_index;
        logic                     row_done;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0] row_length;
        logic [INV_W-1:0] inv_dy;
        logic [INV_W-1:0] inv_dz;
        logic             gravity_enable;
        logic             advection_enable;
    } t_cfg;

    // One sample's worth of cell work, handed from front to back.
    typedef struct packed {
        logic [LEN_W-1:0] col;
        logic [LEN_W-1:0] len;
        logic [ROW_W-1:0] row_idx;
        logic             multi;
        logic [1:0]       line_slot;
        logic             bg_slot;
    } t_job;

    // Line store and background write from the front.
    typedef struct packed {
        logic               en;
        logic [1:0]         slot;
        logic [COL_W-1:0]   col;
        logic [WORD_W-1:0]  word;
        logic               bg_slot;
        logic [WORD_W-1:0]  bg_word;
    } t_mem_wr;

    // Saturate a wide signed value to the data width.
    function automatic logic signed [DATA_W-1:0] sat(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (x > hi) begin
            sat = hi[DATA_W-1:0];
        end else if (x < lo) begin
            sat = lo[DATA_W-1:0];
        end else begin
            sat = x[DATA_W-1:0];
        end
    endfunction

    // Saturating add of two data-width values.
    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        sat_add = sat(SUM_W'(a) + SUM_W'(b));
    endfunction

    // Shift right by FRAC_W plus extra, rounding half away from zero, then saturate.
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p, input logic [1:0] extra);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        logic [PROD_W-1:0] bound;
        neg = p[PROD_W-1];
        mag = neg ? PROD_W'(-p) : PROD_W'(p);
        case (extra)
            2'd1:    q = (mag + (PROD_W'(1) << FRAC_W)) >> (FRAC_W + 1);
            2'd2:    q = (mag + (PROD_W'(1) << (FRAC_W + 1))) >> (FRAC_W + 2);
            default: q = (mag + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
        endcase
        bound = neg ? (PROD_W'(1) << (DATA_W - 1)) : ((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
        if (q > bound) begin
            q = bound;
        end
        round_sat = neg ? -q[DATA_W-1:0] : q[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/ers_front.sv
`default_nettype none
module ers_front #(
    parameter int MAX_COLS = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  ers_pkg::t_in_item i_item,
    input  ers_pkg::t_cfg    i_cfg,
    input  wire              i_q_full,
    input  wire              i_drained,
    output ers_pkg::t_mem_wr o_wr,
    output logic             o_push,
    output ers_pkg::t_job    o_job
);

    localparam int LW = ers_pkg::LEN_W;

    logic [LW-1:0]              r_col;
    logic [ers_pkg::ROW_W-1:0]  r_row;
    logic [1:0]                 r_lslot;
    logic                       r_bslot;

    logic [LW-1:0]              len;
    logic [LW-1:0]              c_raw;
    logic [LW-1:0]              c;
    logic [ers_pkg::ROW_W-1:0]  row_cnt;
    logic [1:0]                 lslot;
    logic                       bslot;
    logic                       last;
    logic                       accept;

    // Effective row length, clamped to the supported range.
    always_comb begin
        if (i_cfg.row_length < LW'(3)) begin
            len = LW'(3);
        end else if (i_cfg.row_length > LW'(MAX_COLS)) begin
            len = LW'(MAX_COLS);
        end else begin
            len = i_cfg.row_length;
        end
    end

    // A new grid restarts all counts with this sample.
    assign c_raw   = i_item.first_of_grid ? '0 : r_col;
    assign c       = (c_raw > len - LW'(1)) ? len - LW'(1) : c_raw;
    assign row_cnt = i_item.first_of_grid ? '0 : r_row;
    assign lslot   = i_item.first_of_grid ? 2'd0 : r_lslot;
    assign bslot   = i_item.first_of_grid ? 1'b0 : r_bslot;
    assign last    = (c == len - LW'(1));

    // A row may only start overwriting the oldest line once the back has finished with it.
    assign o_ready = !i_q_full && ((c != '0) || i_drained);
    assign accept  = i_valid && o_ready;

    // Line store write of this sample.
    always_comb begin
        o_wr.en      = accept;
        o_wr.slot    = lslot;
        o_wr.col     = ers_pkg::COL_W'(c);
        o_wr.word    = {i_item.vel_y, i_item.vel_z, i_item.density_pert};
        o_wr.bg_slot = bslot;
        o_wr.bg_word = {i_item.density_bg, i_item.gravity_val, i_item.gravity_grad};
    end

    // Classify: interior rows emit one cell, or three on the row's last sample.
    assign o_push         = accept && (row_cnt >= ers_pkg::ROW_W'(2)) && (c >= LW'(2));
    assign o_job.col       = c;
    assign o_job.len       = len;
    assign o_job.row_idx   = row_cnt - ers_pkg::ROW_W'(1);
    assign o_job.multi     = last;
    assign o_job.line_slot = lslot;
    assign o_job.bg_slot   = bslot;

    // Row and column counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_lslot <= 2'd0;
            r_bslot <= 1'b0;
        end else if (accept) begin
            if (last) begin
                r_col   <= '0;
                r_row   <= (row_cnt == '1) ? row_cnt : row_cnt + ers_pkg::ROW_W'(1);
                r_lslot <= (lslot == 2'd2) ? 2'd0 : lslot + 2'd1;
                r_bslot <= !bslot;
            end else begin
                r_col   <= c + LW'(1);
                r_row   <= row_cnt;
                r_lslot <= lslot;
                r_bslot <= bslot;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/ers_fifo.sv
`default_nettype none
module ers_fifo (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  ers_pkg::t_job i_job,
    input  wire           i_pop,
    output ers_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    ers_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ers_line_mem.sv
`default_nettype none
module ers_line_mem #(
    parameter int MAX_COLS = 64
) (
    input  wire                           i_clk,
    input  ers_pkg::t_mem_wr              i_wr,
    input  wire [1:0]                     i_rd_slot,
    input  wire [$clog2(MAX_COLS)-1:0]    i_rd_col,
    output logic [ers_pkg::WORD_W-1:0]    o_rd_word,
    input  wire                           i_bg_slot,
    output logic [ers_pkg::WORD_W-1:0]    o_bg_word
);

    localparam int DEPTH = 3 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);

    logic [ers_pkg::WORD_W-1:0] r_lines [DEPTH];
    logic [ers_pkg::WORD_W-1:0] r_bg [2];
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;

    assign wr_addr = AW'(i_wr.slot) * AW'(MAX_COLS) + AW'(i_wr.col[CW-1:0]);
    assign rd_addr = AW'(i_rd_slot) * AW'(MAX_COLS) + AW'(i_rd_col);

    // Three rows of samples: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_lines[wr_addr] <= i_wr.word;
        end
        o_rd_word <= r_lines[rd_addr];
    end

    // Row background values of the last two rows.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_bg[i_wr.bg_slot] <= i_wr.bg_word;
        end
    end

    assign o_bg_word = r_bg[i_bg_slot];

endmodule
`default_nettype wire

// File: rtl/ers_back.sv
`default_nettype none
module ers_back #(
    parameter int MAX_COLS = 64
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  ers_pkg::t_cfg                 i_cfg,
    input  ers_pkg::t_job                 i_head,
    input  wire                           i_empty,
    output logic                          o_pop,
    output logic                          o_busy,
    output logic [1:0]                    o_rd_slot,
    output logic [$clog2(MAX_COLS)-1:0]   o_rd_col,
    input  wire [ers_pkg::WORD_W-1:0]     i_rd_word,
    output logic                          o_bg_slot,
    input  wire [ers_pkg::WORD_W-1:0]     i_bg_word,
    output logic                          o_valid,
    input  wire                           i_ready,
    output ers_pkg::t_out_item            o_item
);

    localparam int DW = ers_pkg::DATA_W;
    localparam int LW = ers_pkg::LEN_W;
    localparam int CW = $clog2(MAX_COLS);
    localparam int NTAP = 9;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // Stencil taps in the order they are fetched.
    localparam logic [3:0] T_MJM = 4'd0;
    localparam logic [3:0] T_MJ  = 4'd1;
    localparam logic [3:0] T_MJP = 4'd2;
    localparam logic [3:0] T_UJ  = 4'd3;
    localparam logic [3:0] T_DJ  = 4'd4;
    localparam logic [3:0] T_UJP = 4'd5;
    localparam logic [3:0] T_UJM = 4'd6;
    localparam logic [3:0] T_DJP = 4'd7;
    localparam logic [3:0] T_DJM = 4'd8;

    // Product steps of the microprogram.
    localparam logic [4:0] P_KYY  = 5'd0;
    localparam logic [4:0] P_KZZ  = 5'd1;
    localparam logic [4:0] P_KYZ  = 5'd2;
    localparam logic [4:0] P_DVDY = 5'd3;
    localparam logic [4:0] P_DVDZ = 5'd4;
    localparam logic [4:0] P_DWDY = 5'd5;
    localparam logic [4:0] P_DWDZ = 5'd6;
    localparam logic [4:0] P_DPDZ = 5'd7;
    localparam logic [4:0] P_D2V  = 5'd8;
    localparam logic [4:0] P_D2W  = 5'd9;
    localparam logic [4:0] P_MV   = 5'd10;
    localparam logic [4:0] P_MW   = 5'd11;
    localparam logic [4:0] P_G1   = 5'd12;
    localparam logic [4:0] P_G2   = 5'd13;
    localparam logic [4:0] P_S1   = 5'd14;
    localparam logic [4:0] P_S2   = 5'd15;
    localparam logic [4:0] P_S3   = 5'd16;
    localparam logic [4:0] P_S4   = 5'd17;
    localparam logic [4:0] P_S5   = 5'd18;
    localparam logic [4:0] P_S6   = 5'd19;
    localparam logic [4:0] P_S7   = 5'd20;
    localparam logic [4:0] P_T1   = 5'd21;
    localparam logic [4:0] P_T2   = 5'd22;
    localparam logic [4:0] P_A1   = 5'd23;
    localparam logic [4:0] P_A2   = 5'd24;

    logic [2:0]                      r_state;
    ers_pkg::t_job                   r_job;
    logic [1:0]                      r_sub;
    logic [3:0]                      r_rcnt;
    logic [4:0]                      r_step;
    logic [1:0]                      r_phase;
    logic [ers_pkg::WORD_W-1:0]      r_tap [NTAP];
    logic signed [ers_pkg::PROD_W-1:0] r_prod;
    logic signed [DW-1:0]            r_mres;
    logic signed [DW-1:0]            r_kyy, r_kzz, r_kyz;
    logic signed [DW-1:0]            r_dvdy, r_dvdz, r_dwdy, r_dwdz, r_dpdz;
    logic signed [DW-1:0]            r_d2v, r_d2w, r_mv, r_mw;
    logic signed [DW-1:0]            r_gacc, r_sacc, r_tacc, r_aacc, r_rhs;
    ers_pkg::t_out_item              r_out;
    logic                            r_valid;

    logic [LW-1:0]                   j, jm, jp;
    logic [1:0]                      up_s, md_s, dn_s;
    logic [1:0]                      tap_slot;
    logic [LW-1:0]                   tap_col;
    logic signed [ers_pkg::OPW-1:0]  op_a, op_b;
    logic [1:0]                      op_sh;
    logic signed [DW-1:0]            v_mjm, v_mj, v_mjp, v_uj, v_dj, v_ujp, v_ujm, v_djp, v_djm;
    logic signed [DW-1:0]            w_mjm, w_mj, w_mjp, w_uj, w_dj, w_ujp, w_ujm, w_djp, w_djm;
    logic signed [DW-1:0]            p_mj, p_uj, p_dj;
    logic signed [DW-1:0]            bg_rho0, bg_g, bg_gg;
    logic                            last_cell;

    // Cell column and its periodic neighbors.
    always_comb begin
        if (r_job.multi) begin
            case (r_sub)
                2'd0:    j = r_job.len - LW'(2);
                2'd1:    j = r_job.len - LW'(1);
                default: j = '0;
            endcase
        end else begin
            j = r_job.col - LW'(1);
        end
        jm = (j == '0) ? r_job.len - LW'(1) : j - LW'(1);
        jp = (j + LW'(1) >= r_job.len) ? '0 : j + LW'(1);
    end

    assign last_cell = !r_job.multi || (r_sub == 2'd2);

    // Line slots: newest row is up, the one before it the center row, the oldest down.
    assign up_s = r_job.line_slot;
    assign md_s = (r_job.line_slot == 2'd0) ? 2'd2 : r_job.line_slot - 2'd1;
    assign dn_s = (r_job.line_slot == 2'd2) ? 2'd0 : r_job.line_slot + 2'd1;

    // Address of the tap being fetched.
    always_comb begin
        case (r_rcnt)
            T_MJM:   begin tap_slot = md_s; tap_col = jm; end
            T_MJ:    begin tap_slot = md_s; tap_col = j;  end
            T_MJP:   begin tap_slot = md_s; tap_col = jp; end
            T_UJ:    begin tap_slot = up_s; tap_col = j;  end
            T_DJ:    begin tap_slot = dn_s; tap_col = j;  end
            T_UJP:   begin tap_slot = up_s; tap_col = jp; end
            T_UJM:   begin tap_slot = up_s; tap_col = jm; end
            T_DJP:   begin tap_slot = dn_s; tap_col = jp; end
            T_DJM:   begin tap_slot = dn_s; tap_col = jm; end
            default: begin tap_slot = md_s; tap_col = j;  end
        endcase
    end

    assign o_rd_slot = tap_slot;
    assign o_rd_col  = tap_col[CW-1:0];
    assign o_bg_slot = !r_job.bg_slot;

    // Unpack the fetched taps and the row background.
    assign v_mjm = r_tap[T_MJM][3*DW-1:2*DW];
    assign v_mj  = r_tap[T_MJ][3*DW-1:2*DW];
    assign v_mjp = r_tap[T_MJP][3*DW-1:2*DW];
    assign v_uj  = r_tap[T_UJ][3*DW-1:2*DW];
    assign v_dj  = r_tap[T_DJ][3*DW-1:2*DW];
    assign v_ujp = r_tap[T_UJP][3*DW-1:2*DW];
    assign v_ujm = r_tap[T_UJM][3*DW-1:2*DW];
    assign v_djp = r_tap[T_DJP][3*DW-1:2*DW];
    assign v_djm = r_tap[T_DJM][3*DW-1:2*DW];
    assign w_mjm = r_tap[T_MJM][2*DW-1:DW];
    assign w_mj  = r_tap[T_MJ][2*DW-1:DW];
    assign w_mjp = r_tap[T_MJP][2*DW-1:DW];
    assign w_uj  = r_tap[T_UJ][2*DW-1:DW];
    assign w_dj  = r_tap[T_DJ][2*DW-1:DW];
    assign w_ujp = r_tap[T_UJP][2*DW-1:DW];
    assign w_ujm = r_tap[T_UJM][2*DW-1:DW];
    assign w_djp = r_tap[T_DJP][2*DW-1:DW];
    assign w_djm = r_tap[T_DJM][2*DW-1:DW];
    assign p_mj  = r_tap[T_MJ][DW-1:0];
    assign p_uj  = r_tap[T_UJ][DW-1:0];
    assign p_dj  = r_tap[T_DJ][DW-1:0];
    assign bg_rho0 = i_bg_word[3*DW-1:2*DW];
    assign bg_g    = i_bg_word[2*DW-1:DW];
    assign bg_gg   = i_bg_word[DW-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a  = '0;
        op_b  = '0;
        op_sh = 2'd0;
        case (r_step)
            P_KYY:  begin op_a = ers_pkg::OPW'(i_cfg.inv_dy); op_b = ers_pkg::OPW'(i_cfg.inv_dy); end
            P_KZZ:  begin op_a = ers_pkg::OPW'(i_cfg.inv_dz); op_b = ers_pkg::OPW'(i_cfg.inv_dz); end
            P_KYZ:  begin op_a = ers_pkg::OPW'(i_cfg.inv_dy); op_b = ers_pkg::OPW'(i_cfg.inv_dz); end
            P_DVDY: begin
                op_a  = ers_pkg::OPW'(v_mjp) - ers_pkg::OPW'(v_mjm);
                op_b  = ers_pkg::OPW'(i_cfg.inv_dy);
                op_sh = 2'd1;
            end
            P_DVDZ: begin
                op_a  = ers_pkg::OPW'(v_uj) - ers_pkg::OPW'(v_dj);
                op_b  = ers_pkg::OPW'(i_cfg.inv_dz);
                op_sh = 2'd1;
            end
            P_DWDY: begin
                op_a  = ers_pkg::OPW'(w_mjp) - ers_pkg::OPW'(w_mjm);
                op_b  = ers_pkg::OPW'(i_cfg.inv_dy);
                op_sh = 2'd1;
            end
            P_DWDZ: begin
                op_a  = ers_pkg::OPW'(w_uj) - ers_pkg::OPW'(w_dj);
                op_b  = ers_pkg::OPW'(i_cfg.inv_dz);
                op_sh = 2'd1;
            end
            P_DPDZ: begin
                op_a  = ers_pkg::OPW'(p_uj) - ers_pkg::OPW'(p_dj);
                op_b  = ers_pkg::OPW'(i_cfg.inv_dz);
                op_sh = 2'd1;
            end
            P_D2V: begin
                op_a = ers_pkg::OPW'(v_mjm) + ers_pkg::OPW'(v_mjp) - (ers_pkg::OPW'(v_mj) <<< 1);
                op_b = ers_pkg::OPW'(r_kyy);
            end
            P_D2W: begin
                op_a = ers_pkg::OPW'(w_dj) + ers_pkg::OPW'(w_uj) - (ers_pkg::OPW'(w_mj) <<< 1);
                op_b = ers_pkg::OPW'(r_kzz);
            end
            P_MV: begin
                op_a  = ers_pkg::OPW'(v_ujp) - ers_pkg::OPW'(v_ujm)
                      - ers_pkg::OPW'(v_djp) + ers_pkg::OPW'(v_djm);
                op_b  = ers_pkg::OPW'(r_kyz);
                op_sh = 2'd2;
            end
            P_MW: begin
                op_a  = ers_pkg::OPW'(w_ujp) - ers_pkg::OPW'(w_ujm)
                      - ers_pkg::OPW'(w_djp) + ers_pkg::OPW'(w_djm);
                op_b  = ers_pkg::OPW'(r_kyz);
                op_sh = 2'd2;
            end
            P_G1: begin op_a = ers_pkg::OPW'(bg_g);   op_b = ers_pkg::OPW'(r_dpdz); end
            P_G2: begin op_a = ers_pkg::OPW'(p_mj);   op_b = ers_pkg::OPW'(bg_gg);  end
            P_S1: begin op_a = ers_pkg::OPW'(v_mj);   op_b = ers_pkg::OPW'(r_d2v);  end
            P_S2: begin op_a = ers_pkg::OPW'(w_mj);   op_b = ers_pkg::OPW'(r_d2w);  end
            P_S3: begin op_a = ers_pkg::OPW'(r_dvdy); op_b = ers_pkg::OPW'(r_dvdy); end
            P_S4: begin op_a = ers_pkg::OPW'(r_dwdz); op_b = ers_pkg::OPW'(r_dwdz); end
            P_S5: begin op_a = ers_pkg::OPW'(r_dwdy); op_b = ers_pkg::OPW'(r_dvdz); end
            P_S6: begin op_a = ers_pkg::OPW'(v_mj);   op_b = ers_pkg::OPW'(r_mw);   end
            P_S7: begin op_a = ers_pkg::OPW'(w_mj);   op_b = ers_pkg::OPW'(r_mv);   end
            P_T1: begin op_a = ers_pkg::OPW'(v_mj);   op_b = ers_pkg::OPW'(r_dwdy); end
            P_T2: begin op_a = ers_pkg::OPW'(w_mj);   op_b = ers_pkg::OPW'(r_dwdz); end
            P_A1: begin op_a = ers_pkg::OPW'(bg_rho0); op_b = ers_pkg::OPW'(r_sacc); end
            P_A2: begin op_a = ers_pkg::OPW'(r_dpdz); op_b = ers_pkg::OPW'(r_tacc); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_item  = r_out;

    // Tap capture: the word of tap k arrives in the cycle after its address is presented.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_READ) && (r_rcnt != '0)) begin
            r_tap[r_rcnt - 4'd1] <= i_rd_word;
        end
    end

    // Multiplier: product, then rounding and saturation, then write-back.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            case (r_phase)
                2'd0: r_prod <= op_a * op_b;
                2'd1: r_mres <= ers_pkg::round_sat(r_prod, op_sh);
                default: begin
                    case (r_step)
                        P_KYY:  r_kyy  <= r_mres;
                        P_KZZ:  r_kzz  <= r_mres;
                        P_KYZ:  r_kyz  <= r_mres;
                        P_DVDY: r_dvdy <= r_mres;
                        P_DVDZ: r_dvdz <= r_mres;
                        P_DWDY: r_dwdy <= r_mres;
                        P_DWDZ: r_dwdz <= r_mres;
                        P_DPDZ: r_dpdz <= r_mres;
                        P_D2V:  r_d2v  <= r_mres;
                        P_D2W:  r_d2w  <= r_mres;
                        P_MV:   r_mv   <= r_mres;
                        P_MW:   r_mw   <= r_mres;
                        P_G1:   r_gacc <= r_mres;
                        P_G2:   r_gacc <= ers_pkg::sat_add(r_gacc, r_mres);
                        P_S1:   r_sacc <= r_mres;
                        P_S5:   r_sacc <= ers_pkg::sat_add(r_sacc,
                                    ers_pkg::sat(ers_pkg::SUM_W'(r_mres) <<< 1));
                        P_T1:   r_tacc <= r_mres;
                        P_T2:   r_tacc <= ers_pkg::sat_add(r_tacc, r_mres);
                        P_A1:   r_aacc <= r_mres;
                        P_A2:   r_aacc <= ers_pkg::sat_add(r_aacc, r_mres);
                        default: r_sacc <= ers_pkg::sat_add(r_sacc, r_mres);
                    endcase
                end
            endcase
        end
    end

    // Final combination of the enabled terms.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            if (r_phase == 2'd0) begin
                r_rhs <= i_cfg.gravity_enable ? ers_pkg::sat(-ers_pkg::SUM_W'(r_gacc)) : '0;
            end else begin
                r_rhs <= i_cfg.advection_enable
                       ? ers_pkg::sat(ers_pkg::SUM_W'(r_rhs) - ers_pkg::SUM_W'(r_aacc)) : r_rhs;
            end
        end
    end

    // Cell sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
            r_rcnt  <= '0;
            r_step  <= '0;
            r_phase <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_head;
                        r_sub   <= 2'd0;
                        r_rcnt  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_rcnt == 4'(NTAP)) begin
                        r_step  <= P_KYY;
                        r_phase <= 2'd0;
                        r_state <= S_MUL;
                    end else begin
                        r_rcnt <= r_rcnt + 4'd1;
                    end
                end
                S_MUL: begin
                    if (r_phase == 2'd2) begin
                        r_phase <= 2'd0;
                        if (r_step == P_A2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end else begin
                        r_phase <= r_phase + 2'd1;
                    end
                end
                S_FIN: begin
                    if (r_phase == 2'd0) begin
                        r_phase <= 2'd1;
                    end else begin
                        r_phase <= 2'd0;
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        if (last_cell) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sub   <= r_sub + 2'd1;
                            r_rcnt  <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result fields, assembled combinationally from the registered cell state.
    always_comb begin
        r_out.rhs_value = r_rhs;
        r_out.row_index = r_job.row_idx;
        r_out.col_index = ers_pkg::COL_W'(j);
        r_out.row_done  = r_job.multi && (r_sub == 2'd2);
    end

endmodule
`default_nettype wire

// File: rtl/elliptic_rhs_stencil_2d.sv
// Streaming right-hand side of the elliptic pressure equation on a 2D grid, signed Q16.16.
// Samples enter in raster order; the front writes them into a three-row line store and
// queues cell work, and the back computes one cell at a time with a single shared
// multiplier, emitting results for the row before the incoming one. Once started, a cell
// fetches nine stencil taps through the line store's one read port, then forms 25
// products on the shared multiplier, each rounded, saturated and written back, combines
// the enabled terms and hands its result off when the receiver is ready; the result
// waits while the receiver holds off. A job taken from the queue yields one cell, or
// three for the last sample of a row; the front keeps queueing jobs while there is room.
// The first sample of a row is held until all queued cells of the previous row are done.
`default_nettype none
module elliptic_rhs_stencil_2d #(
    parameter int MAX_COLS = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  ers_pkg::t_in_item                 i_item,
    output logic                              o_valid,
    input  wire                               i_ready,
    output ers_pkg::t_out_item                o_item,
    input  wire                               i_cfg_we,
    input  wire [ers_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [ers_pkg::INV_W-1:0]          i_cfg_data
);

    ers_pkg::t_cfg              r_cfg;
    ers_pkg::t_mem_wr           wr;
    ers_pkg::t_job              job;
    ers_pkg::t_job              head;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_empty;
    logic                       busy;
    logic [1:0]                 rd_slot;
    logic [$clog2(MAX_COLS)-1:0] rd_col;
    logic [ers_pkg::WORD_W-1:0] rd_word;
    logic                       bg_slot;
    logic [ers_pkg::WORD_W-1:0] bg_word;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_length       <= ers_pkg::LEN_W'(64);
            r_cfg.inv_dy           <= ers_pkg::INV_W'(65536);
            r_cfg.inv_dz           <= ers_pkg::INV_W'(65536);
            r_cfg.gravity_enable   <= 1'b1;
            r_cfg.advection_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ers_pkg::REG_ROW_LENGTH: r_cfg.row_length <= i_cfg_data[ers_pkg::LEN_W-1:0];
                ers_pkg::REG_INV_DY:     r_cfg.inv_dy     <= i_cfg_data;
                ers_pkg::REG_INV_DZ:     r_cfg.inv_dz     <= i_cfg_data;
                ers_pkg::REG_GRAV_EN:    r_cfg.gravity_enable   <= i_cfg_data[0];
                ers_pkg::REG_ADV_EN:     r_cfg.advection_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ers_front #(.MAX_COLS(MAX_COLS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_q_full  (q_full),
        .i_drained (q_empty && !busy),
        .o_wr      (wr),
        .o_push    (push),
        .o_job     (job)
    );

    ers_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ers_line_mem #(.MAX_COLS(MAX_COLS)) u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_slot (rd_slot),
        .i_rd_col  (rd_col),
        .o_rd_word (rd_word),
        .i_bg_slot (bg_slot),
        .o_bg_word (bg_word)
    );

    ers_back #(.MAX_COLS(MAX_COLS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_head    (head),
        .i_empty   (q_empty),
        .o_pop     (pop),
        .o_busy    (busy),
        .o_rd_slot (rd_slot),
        .o_rd_col  (rd_col),
        .i_rd_word (rd_word),
        .o_bg_slot (bg_slot),
        .i_bg_word (bg_word),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule
`default_nettype wire
